// ===== hw/rtl/utf8sd_pkg.sv =====
// Package for the strict UTF-8 stream decoder: result word type, sizing
// constants and the lead byte and overlong lookup functions.
// No dependencies.
package utf8sd_pkg;

    localparam int unsigned MaxSeqBytesDef = 6;
    localparam int unsigned CodeW          = 31;
    localparam int unsigned QueueDepth     = 3;

    typedef struct packed {
        logic [CodeW-1:0] code_point;
        logic             invalid;
        logic             last_of_run;
    } t_result;

    // Sequence length of a lead byte 0xC0-0xFF; zero when unusable.
    function automatic logic [2:0] lead_length(input logic [7:0] b, input logic [2:0] max_len);
        logic [2:0] len;
        len = 3'd0;
        if (b < 8'hE0)      len = 3'd2;
        else if (b < 8'hF0) len = 3'd3;
        else if (b < 8'hF8) len = 3'd4;
        else if (b < 8'hFC) len = 3'd5;
        else if (b < 8'hFE) len = 3'd6;
        if (len > max_len) len = 3'd0;
        return len;
    endfunction

    function automatic logic [7:0] lead_mask(input logic [2:0] len);
        logic [7:0] m;
        unique case (len)
            3'd2:    m = 8'h1F;
            3'd3:    m = 8'h0F;
            3'd4:    m = 8'h07;
            3'd5:    m = 8'h03;
            3'd6:    m = 8'h01;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Smallest value a sequence of this length may carry.
    function automatic logic [CodeW-1:0] min_value(input logic [2:0] len);
        logic [CodeW-1:0] v;
        unique case (len)
            3'd0, 3'd1: v = 31'h0000_0000;
            3'd2:       v = 31'h0000_0080;
            3'd3:       v = 31'h0000_0800;
            3'd4:       v = 31'h0001_0000;
            3'd5:       v = 31'h0020_0000;
            default:    v = 31'h0400_0000;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/utf8_strict_stream_decoder.sv =====
// Strict UTF-8 stream decoder, legacy sequences up to six bytes.
// Registered result: with the queue empty, a word shows in the cycle after its byte.
// Throughput: one byte per cycle while o_stall is low; with the output free, a byte
// giving two results stalls the input while its second word drains from the queue.
// Reset: synchronous active low; closes any open sequence and empties the queue.
// Depends on utf8sd_pkg.
module utf8_strict_stream_decoder #(
    parameter int unsigned MAX_SEQUENCE_BYTES = utf8sd_pkg::MaxSeqBytesDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_byte_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [utf8sd_pkg::CodeW-1:0] o_code_point,
    output logic                        o_invalid,
    output logic                        o_last_of_run
);
    import utf8sd_pkg::*;

    localparam logic [2:0] MaxLen = 3'(MAX_SEQUENCE_BYTES);

    logic [CodeW-1:0] r_code, n_code;
    logic [2:0]       r_rem, n_rem;
    logic [2:0]       r_len, n_len;
    logic [1:0]       r_count;
    t_result          r_q [QueueDepth];
    t_result          n_q [QueueDepth];

    t_result          res0, res1, fr;
    logic [1:0]       push;
    logic             accept, pop, is_cont, fresh, has_fr, bad;
    logic [CodeW-1:0] acc;
    logic [2:0]       ll;
    logic [1:0]       base, base1;

    assign accept  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign o_stall = r_count > 2'd1;
    assign o_valid = r_count != 2'd0;
    assign o_code_point  = r_q[0].code_point;
    assign o_invalid     = r_q[0].invalid;
    assign o_last_of_run = r_q[0].last_of_run;

    assign is_cont = i_byte_in[7:6] == 2'b10;
    assign acc     = {r_code[CodeW-7:0], i_byte_in[5:0]};
    assign ll      = lead_length(i_byte_in, MaxLen);
    assign bad     = (acc < min_value(r_len))
                  || (acc >= 31'h0000_D800 && acc <= 31'h0000_DFFF)
                  || acc == 31'h0000_FFFE || acc == 31'h0000_FFFF;

    always_comb begin
        res0   = '0;
        res1   = '0;
        fr     = '0;
        has_fr = 1'b0;
        push   = 2'd0;
        fresh  = 1'b1;
        n_code = r_code;
        n_rem  = r_rem;
        n_len  = r_len;
        if (r_rem != 3'd0) begin
            if (is_cont) begin
                fresh  = 1'b0;
                n_code = acc;
                n_rem  = r_rem - 3'd1;
                if (r_rem == 3'd1) begin
                    res0.code_point = bad ? '0 : acc;
                    res0.invalid    = bad;
                    push   = 2'd1;
                    n_code = '0;
                    n_len  = 3'd0;
                end
            end else begin
                res0.invalid = 1'b1;
                push   = 2'd1;
                n_code = '0;
                n_rem  = 3'd0;
                n_len  = 3'd0;
            end
        end
        if (fresh) begin
            if (!i_byte_in[7]) begin
                fr.code_point = CodeW'(i_byte_in);
                has_fr = 1'b1;
            end else if (is_cont || ll == 3'd0) begin
                fr.invalid = 1'b1;
                has_fr = 1'b1;
            end else begin
                n_code = CodeW'(i_byte_in & lead_mask(ll));
                n_len  = ll;
                n_rem  = ll - 3'd1;
            end
            if (has_fr) begin
                if (push == 2'd0) begin
                    res0 = fr;
                    push = 2'd1;
                end else begin
                    res1 = fr;
                    push = 2'd2;
                end
            end
        end
        res0.last_of_run = push == 2'd1;
        res1.last_of_run = 1'b1;
    end

    assign base  = r_count - {1'b0, pop};
    assign base1 = base + 2'd1;

    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = pop ? r_q[2] : r_q[1];
        n_q[2] = r_q[2];
        if (accept && push != 2'd0) n_q[base] = res0;
        if (accept && push == 2'd2) n_q[base1] = res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code  <= '0;
            r_rem   <= 3'd0;
            r_len   <= 3'd0;
            r_count <= 2'd0;
        end else begin
            if (accept) begin
                r_code <= n_code;
                r_rem  <= n_rem;
                r_len  <= n_len;
            end
            r_count <= base + (accept ? push : 2'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
        r_q[2] <= n_q[2];
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd3) else $error("result queue overrun");
    a_pair_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> r_count >= 2'd2)
        else $error("first of two results without its partner queued");
    a_zero_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_code_point == '0)
        else $error("invalid word carries a code point");
    a_seq_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem != 3'd0 |-> r_len >= 3'd2 && r_rem < r_len && r_len <= MaxLen)
        else $error("open sequence state inconsistent");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for utf8_strict_stream_decoder: byte stream
// stimulus, a decoding predictor and an in-order check of every result word.
// Depends on utf8sd_pkg and the decoder RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import utf8sd_pkg::*;

    localparam int MaxLen     = int'(MaxSeqBytesDef);
    localparam int NumRandom  = 1300;
    localparam int CycleLimit = 1000000;
    localparam int DrainWait  = 20;
    localparam int ReportMax  = 10;

    localparam logic [30:0] SurrogateLo = 31'h0000_D800;
    localparam logic [30:0] SurrogateHi = 31'h0000_DFFF;
    localparam logic [30:0] NonCharLo   = 31'h0000_FFFE;
    localparam logic [30:0] NonCharHi   = 31'h0000_FFFF;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_byte_in;
    logic             o_valid;
    logic             i_stall;
    logic [CodeW-1:0] o_code_point;
    logic             o_invalid;
    logic             o_last_of_run;

    utf8_strict_stream_decoder #(
        .MAX_SEQUENCE_BYTES (MaxLen)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_byte_in     (i_byte_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_point  (o_code_point),
        .o_invalid     (o_invalid),
        .o_last_of_run (o_last_of_run)
    );

    logic [7:0]  byte_backlog [$];
    t_result     decoded_q [$];

    // decoder state as predicted
    logic [30:0] seq_bits;
    logic [2:0]  seq_left;
    logic [2:0]  seq_len;

    int gap_left;
    int bytes_sent;
    int stall_left;
    int cycles;
    int mismatches;
    int bytes_in;
    int words_checked;
    int invalid_words;
    int paired_words;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 65)      return 0;
        else if (r < 90) return $urandom_range(3, 1);
        else if (r < 98) return $urandom_range(12, 4);
        else             return $urandom_range(60, 20);
    endfunction

    function automatic logic [30:0] floor_for(input int len);
        case (len)
            2:       return 31'h0000_0080;
            3:       return 31'h0000_0800;
            4:       return 31'h0001_0000;
            5:       return 31'h0020_0000;
            6:       return 31'h0400_0000;
            default: return 31'h0;
        endcase
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'hE0)      len = 3'd2;
        else if (b < 8'hF0) len = 3'd3;
        else if (b < 8'hF8) len = 3'd4;
        else if (b < 8'hFC) len = 3'd5;
        else if (b < 8'hFE) len = 3'd6;
        else                len = 3'd0;
        if (len > MaxLen) len = 3'd0;
        return len;
    endfunction

    task automatic push_result(input logic [30:0] cp, input logic bad, input logic last);
        t_result r;
        r.code_point  = bad ? '0 : cp;
        r.invalid     = bad;
        r.last_of_run = last;
        decoded_q.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic       cont;
        logic       own;
        logic [2:0] len;
        logic [30:0] cp;
        cont = (b[7:6] == 2'b10);
        len  = lead_len(b);
        if (seq_left != 0 && cont) begin
            seq_bits = {seq_bits[24:0], b[5:0]};
            seq_left = seq_left - 3'd1;
            if (seq_left == 0) begin
                cp = seq_bits;
                push_result(cp, cp < floor_for(int'(seq_len))
                            || (cp >= SurrogateLo && cp <= SurrogateHi)
                            || cp == NonCharLo || cp == NonCharHi, 1'b1);
                seq_bits = '0;
                seq_len  = '0;
            end
        end else begin
            own = !b[7] || cont || len == 0;
            // broken sequence: close it, then take the byte afresh
            if (seq_left != 0) begin
                push_result('0, 1'b1, !own);
                seq_bits = '0;
                seq_left = '0;
                seq_len  = '0;
            end
            if (!b[7]) begin
                push_result({23'd0, b}, 1'b0, 1'b1);
            end else if (own) begin
                push_result('0, 1'b1, 1'b1);
            end else begin
                seq_bits = {23'd0, b & (8'h7F >> len)};
                seq_len  = len;
                seq_left = len - 3'd1;
            end
        end
    endtask

    // first `keep` bytes of the n-byte encoding of cp
    task automatic queue_seq(input logic [30:0] cp, input int n, input int keep);
        logic [7:0]  pfx;
        logic [7:0]  low_mask;
        logic [30:0] part;
        pfx      = 8'hFF << (8 - n);
        low_mask = 8'h7F >> n;
        part     = cp >> (6 * (n - 1));
        byte_backlog.push_back(pfx | (part[7:0] & low_mask));
        for (int k = 1; k < keep; k++) begin
            part = cp >> (6 * (n - 1 - k));
            byte_backlog.push_back({2'b10, part[5:0]});
        end
    endtask

    task automatic note_mismatch(input string what, input t_result want);
        mismatches++;
        if (mismatches <= ReportMax)
            $display("%0t: %s: want cp %h inv %b last %b, got cp %h inv %b last %b",
                     $time, what, want.code_point, want.invalid, want.last_of_run,
                     o_code_point, o_invalid, o_last_of_run);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_byte_in <= 8'h00;
            gap_left = 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                bytes_sent++;
                gap_left = ((bytes_sent % 300) < 60) ? 0 : gap_len();
            end
            if (gap_left > 0 || byte_backlog.size() == 0) begin
                if (gap_left > 0) gap_left--;
                i_valid <= 1'b0;
            end else begin
                i_valid   <= 1'b1;
                i_byte_in <= byte_backlog.pop_front();
            end
        end
    end

    // monitor: predicts from accepted bytes, checks accepted result words
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
            seq_bits   = '0;
            seq_left   = '0;
            seq_len    = '0;
        end else begin
            if (i_valid && !o_stall) begin
                bytes_in++;
                decode_byte(i_byte_in);
            end
            if (o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    want = '0;
                    note_mismatch("unexpected word", want);
                end else begin
                    want = decoded_q.pop_front();
                    words_checked++;
                    if (want.invalid) invalid_words++;
                    if (!want.last_of_run) paired_words++;
                    if (o_code_point !== want.code_point || o_invalid !== want.invalid
                        || o_last_of_run !== want.last_of_run)
                        note_mismatch("word mismatch", want);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if ((cycles % 3000) >= 600) stall_left = gap_len();
            end
        end
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int          kind;
        int          n;
        int          keep;
        int          target;
        logic [7:0]  b;
        logic [30:0] cp;
        i_rst_n   = 1'b0;

        // extremes, stray continuation, unusable leads
        byte_backlog.push_back(8'h00);
        byte_backlog.push_back(8'h7F);
        byte_backlog.push_back(8'h80);
        byte_backlog.push_back(8'hFE);
        byte_backlog.push_back(8'hFF);
        queue_seq(31'h0000_00A9, 2, 2);
        queue_seq(31'h0000_0000, 2, 2);     // overlong
        queue_seq(SurrogateLo, 3, 3);
        queue_seq(31'h7FFF_FFFF, 6, 6);     // longest legacy form
        queue_seq(31'h0000_2022, 3, 1);     // broken by ASCII: two words
        byte_backlog.push_back(8'h41);
        queue_seq(31'h0000_2022, 3, 2);     // broken by a lead, which then completes
        byte_backlog.push_back(8'hC3);
        byte_backlog.push_back(8'hA9);
        byte_backlog.push_back(8'hC3);      // broken by an unusable lead
        byte_backlog.push_back(8'hFF);

        target = byte_backlog.size() + NumRandom;
        while (byte_backlog.size() < target) begin
            kind = $urandom_range(99, 0);
            if (kind < 20) begin
                byte_backlog.push_back(8'($urandom_range(127, 0)));
            end else if (kind < 60) begin
                n = $urandom_range(MaxLen, 2);
                if ($urandom_range(3, 0) == 0)
                    cp = 31'($urandom & ((32'd1 << (5 * n + 1)) - 1));
                else
                    cp = 31'($urandom_range((32'd1 << (5 * n + 1)) - 1, floor_for(n)));
                queue_seq(cp, n, n);
            end else if (kind < 70) begin
                if ($urandom_range(1, 0) == 0) begin
                    n  = $urandom_range(MaxLen, 2);
                    cp = 31'($urandom_range(floor_for(n) - 1, 0));
                end else begin
                    n = $urandom_range(4, 3);
                    case ($urandom_range(2, 0))
                        0:       cp = 31'($urandom_range(SurrogateHi, SurrogateLo));
                        1:       cp = NonCharLo;
                        default: cp = NonCharHi;
                    endcase
                end
                queue_seq(cp, n, n);
            end else if (kind < 85) begin
                n    = $urandom_range(MaxLen, 2);
                keep = $urandom_range(n - 1, 1);
                queue_seq(31'($urandom), n, keep);
                b = 8'($urandom_range(255, 0));
                while (b[7:6] == 2'b10) b = 8'($urandom_range(255, 0));
                byte_backlog.push_back(b);
            end else if (kind < 93) begin
                repeat ($urandom_range(3, 1))
                    byte_backlog.push_back(8'($urandom_range(8'hBF, 8'h80)));
            end else if (kind < 97) begin
                byte_backlog.push_back(8'($urandom_range(8'hFF, 8'hFE)));
            end else begin
                byte_backlog.push_back(8'($urandom_range(255, 0)));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (byte_backlog.size() != 0 || i_valid || decoded_q.size() != 0)
            @(negedge i_clk);
        repeat (DrainWait) @(negedge i_clk);

        $display("%0d bytes decoded, %0d result words checked", bytes_in, words_checked);
        $display("%0d invalid words, %0d bytes giving two words", invalid_words, paired_words);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
